@@ sv/pcc_pkg.sv @@
`timescale 1ns / 1ps

package pcc_pkg;

  localparam int RADIUS_W = 31;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  // register index = byte address / 4
  localparam logic CFG_RADIUS = 1'b0;

endpackage

@@ sv/path_corner_cut.sv @@
`timescale 1ns / 1ps

// Corner chamfer, one vertex per cycle while busy is low. A vertex accepted on
// start passes three front stages, a one-bit-per-stage square root over
// COORD_BITS+1 stages, a clamp stage, a multiply stage, a one-bit-per-stage
// divider over COORD_BITS stages and an output stage. A pass-through vertex
// gives one word. A cut vertex gives two words on consecutive cycles. While
// the first of them is out, busy is high and the whole pipeline holds, so no
// new vertex is taken while that word is out. res_valid_o marks each word for
// one cycle and cannot be held off. corner_radius is written over APB at byte
// address 0; the user must write it only while the pipeline is empty, as the
// block itself does not enforce it.
module path_corner_cut #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcc_pkg::APB_AW-1:0]    paddr,
  input  logic [pcc_pkg::APB_DW-1:0]    pwdata,
  output logic [pcc_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [COORD_BITS-1:0]         prev_x_i,
  input  logic [COORD_BITS-1:0]         prev_y_i,
  input  logic [COORD_BITS-1:0]         cur_x_i,
  input  logic [COORD_BITS-1:0]         cur_y_i,
  input  logic [COORD_BITS-1:0]         next_x_i,
  input  logic [COORD_BITS-1:0]         next_y_i,
  input  logic [COORD_BITS-1:0]         cur_in_x_i,
  input  logic [COORD_BITS-1:0]         cur_in_y_i,
  input  logic [COORD_BITS-1:0]         cur_out_x_i,
  input  logic [COORD_BITS-1:0]         cur_out_y_i,
  input  logic                          pass_through_i,
  output logic                          res_valid_o,
  output logic [COORD_BITS-1:0]         out_x_o,
  output logic [COORD_BITS-1:0]         out_y_o,
  output logic [COORD_BITS-1:0]         out_in_x_o,
  output logic [COORD_BITS-1:0]         out_in_y_o,
  output logic [COORD_BITS-1:0]         out_out_x_o,
  output logic [COORD_BITS-1:0]         out_out_y_o,
  output logic                          last_of_vertex_o
);

  localparam int CB  = COORD_BITS;
  localparam int RW  = pcc_pkg::RADIUS_W;
  localparam int QW  = CB + 1;          // edge length width
  localparam int SW  = 2 * CB + 2;      // sum of squares, even width
  localparam int NW  = CB + RW;         // |e| * r
  localparam int MXW = (QW > RW) ? QW : RW;
  localparam longint unsigned ZLS = (64'd1 << (2 * FRAC_BITS)) / 64'd1000000000000;

  typedef struct packed {
    logic                 v;
    logic                 skip;
    logic [CB-1:0]        cx;
    logic [CB-1:0]        cy;
    logic [CB-1:0]        ix;
    logic [CB-1:0]        iy;
    logic [CB-1:0]        ox;
    logic [CB-1:0]        oy;
    logic [3:0]           neg;
    logic [3:0][CB-1:0]   m;
  } carry_t;

  function automatic logic [CB:0] sdiff(input logic [CB-1:0] a, input logic [CB-1:0] b);
    return {a[CB-1], a} - {b[CB-1], b};
  endfunction

  function automatic logic [CB-1:0] absv(input logic [CB:0] d);
    logic [CB:0] n;
    n = -d;
    return d[CB] ? n[CB-1:0] : d[CB-1:0];
  endfunction

  // ---------------- config ----------------
  logic [RW-1:0] radius_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == pcc_pkg::CFG_RADIUS);
  assign prdata = (paddr[2] == pcc_pkg::CFG_RADIUS) ?
                  {{(pcc_pkg::APB_DW-RW){1'b0}}, radius_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
    end else if (cfg_wr) begin
      radius_q <= pwdata[RW-1:0];
    end
  end

  // ---------------- flow control ----------------
  logic adv;
  logic phase_q;

  // ---------------- stage A: edge vectors ----------------
  carry_t       a_q;
  logic [CB:0]  e1x, e1y, e2x, e2y;

  assign e1x = sdiff(prev_x_i, cur_x_i);
  assign e1y = sdiff(prev_y_i, cur_y_i);
  assign e2x = sdiff(next_x_i, cur_x_i);
  assign e2y = sdiff(next_y_i, cur_y_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
    end else if (adv) begin
      a_q.v    <= start;
      a_q.skip <= pass_through_i;
      a_q.cx   <= cur_x_i;
      a_q.cy   <= cur_y_i;
      a_q.ix   <= cur_in_x_i;
      a_q.iy   <= cur_in_y_i;
      a_q.ox   <= cur_out_x_i;
      a_q.oy   <= cur_out_y_i;
      a_q.neg  <= {e2y[CB], e2x[CB], e1y[CB], e1x[CB]};
      a_q.m    <= {absv(e2y), absv(e2x), absv(e1y), absv(e1x)};
    end
  end

  // ---------------- stage B: squares ----------------
  carry_t                b_q;
  logic [3:0][2*CB-1:0]  b_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q <= '0;
    end else if (adv) begin
      b_q <= a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        b_sq_q[l] <= (2*CB)'(a_q.m[l]) * (2*CB)'(a_q.m[l]);
      end
    end
  end

  // ---------------- stage C + square root ----------------
  carry_t         sc_q   [0:QW];
  logic [SW-1:0]  rad_q  [0:QW][0:1];
  logic [QW:0]    rem_q  [0:QW][0:1];
  logic [QW-1:0]  root_q [0:QW][0:1];
  logic [SW-1:0]  s1, s2;
  logic           zero_len;
  carry_t         sc0_d;

  assign s1 = SW'(b_sq_q[0]) + SW'(b_sq_q[1]);
  assign s2 = SW'(b_sq_q[2]) + SW'(b_sq_q[3]);
  assign zero_len = (s1 <= SW'(ZLS)) || (s2 <= SW'(ZLS));

  always_comb begin
    sc0_d      = b_q;
    sc0_d.skip = b_q.skip || (radius_q == '0) || zero_len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q[0] <= '0;
    end else if (adv) begin
      sc_q[0] <= sc0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rad_q[0][0]  <= s1;
      rad_q[0][1]  <= s2;
      rem_q[0][0]  <= '0;
      rem_q[0][1]  <= '0;
      root_q[0][0] <= '0;
      root_q[0][1] <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_sqrt
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sc_q[k+1] <= '0;
      end else if (adv) begin
        sc_q[k+1] <= sc_q[k];
      end
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [QW+2:0] t, tr, df;
      logic          ge;
      assign t  = {rem_q[k][l], rad_q[k][l][SW-1 -: 2]};
      assign tr = {1'b0, root_q[k][l], 2'b01};
      assign ge = (t >= tr);
      assign df = t - tr;
      always_ff @(posedge clk_i) begin
        if (adv) begin
          rad_q[k+1][l]  <= {rad_q[k][l][SW-3:0], 2'b00};
          rem_q[k+1][l]  <= ge ? df[QW:0] : t[QW:0];
          root_q[k+1][l] <= {root_q[k][l][QW-2:0], ge};
        end
      end
    end
  end

  // ---------------- stage R: clamp radius ----------------
  carry_t           r_q;
  logic [1:0][QW-1:0] r_d_q;
  logic [RW-1:0]    r_r_q;
  logic [MXW-1:0]   h1, h2, rmin;

  assign h1   = MXW'(root_q[QW][0] >> 1);
  assign h2   = MXW'(root_q[QW][1] >> 1);
  always_comb begin
    rmin = MXW'(radius_q);
    if (h1 < rmin) rmin = h1;
    if (h2 < rmin) rmin = h2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0;
    end else if (adv) begin
      r_q <= sc_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_d_q[0] <= root_q[QW][0];
      r_d_q[1] <= root_q[QW][1];
      r_r_q    <= rmin[RW-1:0];
    end
  end

  // ---------------- stage M + divider ----------------
  carry_t               dv_q  [0:CB];
  logic [1:0][QW-1:0]   dd_q  [0:CB];
  logic [QW-1:0]        drem_q[0:CB][0:3];
  logic [CB-1:0]        dqs_q [0:CB][0:3];
  logic [3:0][NW-1:0]   prod;
  logic [3:0][NW+QW-1:0] prod_hi;

  for (genvar l = 0; l < 4; l++) begin : g_mul
    assign prod[l]    = NW'(r_q.m[l]) * NW'(r_r_q);
    assign prod_hi[l] = {{QW{1'b0}}, prod[l]} >> CB;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= '0;
    end else if (adv) begin
      dv_q[0] <= r_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dd_q[0] <= r_d_q;
      for (int l = 0; l < 4; l++) begin
        drem_q[0][l] <= prod_hi[l][QW-1:0];
        dqs_q[0][l]  <= prod[l][CB-1:0];
      end
    end
  end

  for (genvar k = 0; k < CB; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= '0;
      end else if (adv) begin
        dv_q[k+1] <= dv_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dd_q[k+1] <= dd_q[k];
      end
    end
    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [QW:0] t, dx, df;
      logic        ge;
      assign t  = {drem_q[k][l], dqs_q[k][l][CB-1]};
      assign dx = {1'b0, dd_q[k][l/2]};
      assign ge = (t >= dx);
      assign df = t - dx;
      always_ff @(posedge clk_i) begin
        if (adv) begin
          drem_q[k+1][l] <= ge ? df[QW-1:0] : t[QW-1:0];
          dqs_q[k+1][l]  <= {dqs_q[k][l][CB-2:0], ge};
        end
      end
    end
  end

  // ---------------- stage F: anchors ----------------
  logic          f_v_q, f_skip_q;
  logic [CB-1:0] f_cx_q, f_cy_q, f_ix_q, f_iy_q, f_ox_q, f_oy_q;
  logic [3:0][CB-1:0] f_pt_q;
  logic [3:0][CB-1:0] anc;
  logic [3:0][CB-1:0] base;

  assign base = {dv_q[CB].cy, dv_q[CB].cx, dv_q[CB].cy, dv_q[CB].cx};

  for (genvar l = 0; l < 4; l++) begin : g_anc
    logic [CB-1:0] q, off;
    assign q      = dqs_q[CB][l];
    assign off    = dv_q[CB].neg[l] ? (~q + 1'b1) : q;
    assign anc[l] = base[l] + off;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q    <= 1'b0;
      f_skip_q <= 1'b0;
    end else if (adv) begin
      f_v_q    <= dv_q[CB].v;
      f_skip_q <= dv_q[CB].skip;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_cx_q <= dv_q[CB].cx;
      f_cy_q <= dv_q[CB].cy;
      f_ix_q <= dv_q[CB].ix;
      f_iy_q <= dv_q[CB].iy;
      f_ox_q <= dv_q[CB].ox;
      f_oy_q <= dv_q[CB].oy;
      f_pt_q <= anc;
    end
  end

  // first word of a cut holds the pipe while it is out
  assign busy = f_v_q && !f_skip_q && !phase_q;
  assign adv  = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else begin
      phase_q <= busy;
    end
  end

  // ---------------- result word ----------------
  always_comb begin
    res_valid_o      = f_v_q;
    last_of_vertex_o = f_skip_q || phase_q;
    if (f_skip_q) begin
      out_x_o     = f_cx_q;
      out_y_o     = f_cy_q;
      out_in_x_o  = f_ix_q;
      out_in_y_o  = f_iy_q;
      out_out_x_o = f_ox_q;
      out_out_y_o = f_oy_q;
    end else if (phase_q) begin
      out_x_o     = f_pt_q[2];
      out_y_o     = f_pt_q[3];
      out_in_x_o  = f_pt_q[2];
      out_in_y_o  = f_pt_q[3];
      out_out_x_o = f_pt_q[2];
      out_out_y_o = f_pt_q[3];
    end else begin
      out_x_o     = f_pt_q[0];
      out_y_o     = f_pt_q[1];
      out_in_x_o  = f_pt_q[0];
      out_in_y_o  = f_pt_q[1];
      out_out_x_o = f_pt_q[0];
      out_out_y_o = f_pt_q[1];
    end
  end

  // ---------------- checks ----------------
  a_hold_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> res_valid_o && !last_of_vertex_o)
    else $error("hold without first cut word");

  a_second_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> res_valid_o && last_of_vertex_o && !busy)
    else $error("second cut word missing");

  a_cut_handles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !f_skip_q |-> out_in_x_o == out_x_o && out_out_y_o == out_y_o)
    else $error("cut word handles differ from anchor");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int CW = 32;
  localparam int AW = pcc_pkg::APB_AW;
  localparam int DW = pcc_pkg::APB_DW;
  localparam int RW = pcc_pkg::RADIUS_W;
  localparam logic [AW-1:0] RADIUS_ADDR = AW'(int'(pcc_pkg::CFG_RADIUS) * 4);
  localparam int DRAIN_CYCLES = 2 * CW + 20;

  typedef struct {
    logic [CW-1:0] px, py, cx, cy, nx, ny, ix, iy, ox, oy;
    logic          pt;
    logic          known;  // expected word is the vertex itself, no predictor
  } vertex_t;

  typedef struct {
    logic [CW-1:0] x, y, in_x, in_y, out_x, out_y;
    logic          last;
  } anchor_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [DW-1:0] pwdata = '0;
  logic [DW-1:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [CW-1:0] prev_x_i = '0, prev_y_i = '0, cur_x_i = '0, cur_y_i = '0;
  logic [CW-1:0] next_x_i = '0, next_y_i = '0, cur_in_x_i = '0, cur_in_y_i = '0;
  logic [CW-1:0] cur_out_x_i = '0, cur_out_y_i = '0;
  logic pass_through_i = 1'b0;
  logic res_valid_o;
  logic [CW-1:0] out_x_o, out_y_o, out_in_x_o, out_in_y_o, out_out_x_o, out_out_y_o;
  logic last_of_vertex_o;

  path_corner_cut uut (.*);

  always #5 clk_i = ~clk_i;

  logic [RW-1:0] radius;
  anchor_t anchors_due[$];
  int errors = 0;

  task automatic report_mismatch(input string what, input logic [CW-1:0] exp_v,
                                 input logic [CW-1:0] got_v);
    $display("MISMATCH %s: expected %h got %h at %0t", what, exp_v, got_v, $time);
    errors++;
  endtask

  function automatic logic [63:0] isqrt(input logic [127:0] n);
    logic [63:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  // anchor = cur + sign(e) * floor(|e| * r / d)
  function automatic logic [CW-1:0] step_toward(input logic [CW-1:0] c,
      input logic signed [63:0] e, input logic [63:0] r, input logic [63:0] d);
    logic [127:0] q;
    logic [63:0] m;
    m = e < 0 ? -e : e;
    q = ({64'd0, m} * {64'd0, r}) / {64'd0, d};
    return e < 0 ? c - q[CW-1:0] : c + q[CW-1:0];
  endfunction

  function automatic void predict_cut(input vertex_t v);
    logic signed [63:0] cx, cy, e1x, e1y, e2x, e2y;
    logic [127:0] s1, s2;
    logic [63:0] d1, d2, r, m1x, m1y, m2x, m2y;
    anchor_t a;
    cx = {{32{v.cx[CW-1]}}, v.cx};
    cy = {{32{v.cy[CW-1]}}, v.cy};
    e1x = {{32{v.px[CW-1]}}, v.px} - cx;
    e1y = {{32{v.py[CW-1]}}, v.py} - cy;
    e2x = {{32{v.nx[CW-1]}}, v.nx} - cx;
    e2y = {{32{v.ny[CW-1]}}, v.ny} - cy;
    m1x = e1x < 0 ? -e1x : e1x;
    m1y = e1y < 0 ? -e1y : e1y;
    m2x = e2x < 0 ? -e2x : e2x;
    m2y = e2y < 0 ? -e2y : e2y;
    s1 = {64'd0, m1x} * {64'd0, m1x} + {64'd0, m1y} * {64'd0, m1y};
    s2 = {64'd0, m2x} * {64'd0, m2x} + {64'd0, m2y} * {64'd0, m2y};
    // the 1e-6 threshold is zero at Q16.16
    if (v.pt || radius == 0 || s1 == 0 || s2 == 0) begin
      a = '{v.cx, v.cy, v.ix, v.iy, v.ox, v.oy, 1'b1};
      anchors_due = {anchors_due, a};
      return;
    end
    d1 = isqrt(s1);
    d2 = isqrt(s2);
    r = {33'd0, radius};
    if ((d1 >> 1) < r) r = d1 >> 1;
    if ((d2 >> 1) < r) r = d2 >> 1;
    a.x = step_toward(v.cx, e1x, r, d1);
    a.y = step_toward(v.cy, e1y, r, d1);
    a = '{a.x, a.y, a.x, a.y, a.x, a.y, 1'b0};
    anchors_due = {anchors_due, a};
    a.x = step_toward(v.cx, e2x, r, d2);
    a.y = step_toward(v.cy, e2y, r, d2);
    a = '{a.x, a.y, a.x, a.y, a.x, a.y, 1'b1};
    anchors_due = {anchors_due, a};
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (anchors_due.size() == 0) begin
        report_mismatch("unexpected word", '0, out_x_o);
      end else begin
        anchor_t a;
        a = anchors_due.pop_front();
        if (out_x_o !== a.x) report_mismatch("out_x", a.x, out_x_o);
        if (out_y_o !== a.y) report_mismatch("out_y", a.y, out_y_o);
        if (out_in_x_o !== a.in_x) report_mismatch("out_in_x", a.in_x, out_in_x_o);
        if (out_in_y_o !== a.in_y) report_mismatch("out_in_y", a.in_y, out_in_y_o);
        if (out_out_x_o !== a.out_x) report_mismatch("out_out_x", a.out_x, out_out_x_o);
        if (out_out_y_o !== a.out_y) report_mismatch("out_out_y", a.out_y, out_out_y_o);
        if (last_of_vertex_o !== a.last)
          report_mismatch("last_of_vertex", CW'(a.last), CW'(last_of_vertex_o));
      end
    end
  end

  task automatic write_radius(input logic [DW-1:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= RADIUS_ADDR; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    radius = val[RW-1:0];
  endtask

  task automatic drain();
    start <= 1'b0;
    while (anchors_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_vertex(input vertex_t v);
    int gap;
    anchor_t a;
    prev_x_i <= v.px; prev_y_i <= v.py; cur_x_i <= v.cx; cur_y_i <= v.cy;
    next_x_i <= v.nx; next_y_i <= v.ny; cur_in_x_i <= v.ix; cur_in_y_i <= v.iy;
    cur_out_x_i <= v.ox; cur_out_y_i <= v.oy; pass_through_i <= v.pt;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    if (v.known) begin
      a = '{v.cx, v.cy, v.ix, v.iy, v.ox, v.oy, 1'b1};
      anchors_due = {anchors_due, a};
    end else begin
      predict_cut(v);
    end
    gap = $urandom_range(0, 9) < 6 ? 0 :
          ($urandom_range(0, 5) == 0 ? $urandom_range(10, 60) : $urandom_range(1, 4));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic vertex_t mk(input logic [CW-1:0] px, py, cx, cy, nx, ny,
                                 input logic pt, input logic known);
    vertex_t v;
    v = '{px, py, cx, cy, nx, ny, $urandom, $urandom, $urandom, $urandom, pt, known};
    return v;
  endfunction

  function automatic logic [CW-1:0] near(input logic [CW-1:0] c);
    logic [CW-1:0] d;
    d = $urandom >> $urandom_range(0, 31);
    return $urandom_range(0, 1) ? c + d : c - d;
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t v;
    int kind;
    kind = $urandom_range(0, 19);
    v = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom_range(0, 9) == 0, 1'b0);
    if (kind < 14) begin
      // neighbours at a random scale around the vertex
      v.px = near(v.cx); v.py = near(v.cy);
      v.nx = near(v.cx); v.ny = near(v.cy);
    end else if (kind < 16) begin
      if ($urandom_range(0, 1)) begin v.px = v.cx; v.py = v.cy; end
      else begin v.nx = v.cx; v.ny = v.cy; end
    end
    return v;
  endfunction

  vertex_t dir_rows[$];
  logic [DW-1:0] radius_steps[5] = '{32'd1, 32'h0001_0000, 32'hffff_ffff, 32'd0, 32'd3};

  initial begin
    radius = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nothing is cut straight after reset: radius is zero
    send_vertex(mk(32'h10000, 0, 0, 0, 0, 32'h10000, 1'b0, 1'b1));
    drain();
    write_radius(32'h7fff_ffff);

    dir_rows = {
      mk(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
         32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b1),
      mk(32'h5, 32'h6, 32'h5, 32'h6, 32'h9, 32'h9, 1'b0, 1'b1),
      mk(32'h1, 32'h2, 32'h5, 32'h6, 32'h5, 32'h6, 1'b0, 1'b1),
      mk(0, 0, 0, 0, 0, 0, 1'b0, 1'b1),
      mk(32'hffff_0000, 0, 0, 0, 0, 32'h40000, 1'b0, 1'b0),
      mk(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
         32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b0),
      mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
         32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b0),
      mk(32'h101, 32'h200, 32'h100, 32'h200, 32'h100, 32'h1ff, 1'b0, 1'b0),
      mk(32'h30000, 32'h40000, 0, 0, 32'hfffc_0000, 32'hfffd_0000, 1'b0, 1'b0),
      mk(32'hffff_ffff, 32'hffff_ffff, 0, 0, 32'hffff_ffff, 1, 1'b0, 1'b0),
      mk(0, 0, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 0, 1'b0, 1'b0),
      mk(32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f, 32'hf0f0_f0f0,
         32'h5555_5555, 32'haaaa_aaaa, 1'b1, 1'b1)
    };
    foreach (dir_rows[i]) send_vertex(dir_rows[i]);

    for (int i = 0; i < 100; i++) send_vertex(rand_vertex());
    foreach (radius_steps[k]) begin
      drain();
      write_radius(radius_steps[k]);
      for (int i = 0; i < 110; i++) send_vertex(rand_vertex());
    end
    drain();
    write_radius($urandom);
    for (int i = 0; i < 120; i++) send_vertex(rand_vertex());
    drain();

    if (errors == 0)
      $display("path_corner_cut test passed");
    else
      $display("path_corner_cut test failed");
    $finish;
  end

  initial begin
    #3ms;
    $display("path_corner_cut test failed");
    $finish;
  end

endmodule
